/* rtl/fraction_alu_unit_macros.svh */
// ----------------------------------------------------------------------------
// fraction_alu_unit_macros.svh
// Assertion macros used by the fraction ALU checker.
// ----------------------------------------------------------------------------
`ifndef FRACTION_ALU_UNIT_MACROS_SVH
`define FRACTION_ALU_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fraction_alu_unit: check failed");

// next-cycle implication, disabled while reset is asserted
`define FA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fraction_alu_unit: check failed");

`endif

/* rtl/fa_pkg.sv */
// ----------------------------------------------------------------------------
// fa_pkg
// Types and constants of the fraction ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fa_pkg;

	localparam int OUT_W = 33;
	localparam int CMD_W = 3;

	typedef enum logic [CMD_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_RED = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_FIN
	} state_t;

endpackage

/* rtl/fraction_alu_unit.sv */
// ----------------------------------------------------------------------------
// fraction_alu_unit
// Signed fraction add, subtract, multiply, divide and GCD reduction.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries cmd and the fractions a and b; the
// output channel out_valid/out_ready returns res_num, res_den and
// zero_fraction_error, one result per request.
// One request is worked on at a time; in_ready is high only while idle.
// Add, subtract, multiply and divide: three passes of the shared multiplier
// (MUL0 to MUL2), a step to take the denominator (MUL3) and a step to hand
// over (FIN), after which the sequencer returns to idle.
// Reduce: binary GCD on one shared subtractor, then two restoring divisions
// by the GCD on the same subtractor, each giving OPERAND_WIDTH quotient bits,
// then a step to hand over; 0/0 skips the divisions and flags the error.
// Unused opcodes pass a through, going from idle straight to hand-over.
// in_ready returns the cycle after a result is handed over.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls and a second result is finished,
// the unit holds it, and refuses requests, until the output register frees.
// Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fraction_alu_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [fa_pkg::CMD_W-1:0]           cmd,
	input  logic signed [OPERAND_WIDTH-1:0]    a_num,
	input  logic signed [OPERAND_WIDTH-1:0]    a_den,
	input  logic signed [OPERAND_WIDTH-1:0]    b_num,
	input  logic signed [OPERAND_WIDTH-1:0]    b_den,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [fa_pkg::OUT_W-1:0]    res_num,
	output logic signed [fa_pkg::OUT_W-1:0]    res_den,
	output logic                               zero_fraction_error
);

	import fa_pkg::*;

	localparam int W      = OPERAND_WIDTH;
	localparam int PROD_W = 2 * W;
	localparam int EXT_W  = (PROD_W > OUT_W) ? PROD_W : OUT_W;
	localparam int CW     = $clog2(W);

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		return v[W-1] ? unsigned'(-v) : unsigned'(v);
	endfunction

	function automatic logic signed [OUT_W-1:0] apply_sign(input logic [W-1:0] q,
			input logic neg);
		logic signed [OUT_W-1:0] m;
		m = signed'(OUT_W'({1'b0, q}));
		return neg ? -m : m;
	endfunction

	state_t state_q, state_nx;

	logic [CMD_W-1:0]        cmd_q;
	logic signed [W-1:0]     an_q, ad_q, bn_q, bd_q;
	logic [W-1:0]            x_q, y_q, g_q, rem_q, quo_q;
	logic [CW-1:0]           k_q, cnt_q;
	logic signed [OUT_W-1:0] prod_q, num_q, den_q;
	logic                    err_q;
	logic signed [OUT_W-1:0] res_num_q, res_den_q;
	logic                    res_err_q, out_valid_q;

	// shared multiplier
	logic signed [W-1:0]      mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [EXT_W-1:0]  mul_ext;

	// shared subtractor / comparator
	logic [W-1:0] sub_a, sub_b;
	logic [W:0]   diff;
	logic         ge;

	logic [W-1:0] rem_sh, quo_nx, rem_nx, gsrc, y_neg;
	logic         fin_load, in_acc;

	assign mul_p   = mul_a * mul_b;
	assign mul_ext = EXT_W'(mul_p);

	assign diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge   = ~diff[W];

	// remainder stays below the divisor, so its top bit is always clear
	assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
	assign quo_nx = {quo_q[W-2:0], ge};
	assign rem_nx = ge ? diff[W-1:0] : rem_sh;
	assign y_neg  = W'(~diff[W-1:0] + 1'b1);
	assign gsrc   = (x_q == '0) ? y_q : x_q;

	assign in_acc   = in_valid && in_ready;
	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					priority if (cmd == OP_ADD || cmd == OP_SUB || cmd == OP_MUL ||
							cmd == OP_DIV)
						state_nx = ST_MUL0;
					else if (cmd == OP_RED)
						state_nx = ST_GCD;
					else
						state_nx = ST_FIN;
				end
			end
			ST_MUL0: state_nx = ST_MUL1;
			ST_MUL1: state_nx = ST_MUL2;
			ST_MUL2: state_nx = ST_MUL3;
			ST_MUL3: state_nx = ST_FIN;
			ST_GCD: begin
				priority if (x_q == '0 && y_q == '0)
					state_nx = ST_FIN;
				else if (x_q == '0 || y_q == '0)
					state_nx = ST_DIVN;
				else
					state_nx = ST_GCD;
			end
			ST_DIVN: if (cnt_q == '0) state_nx = ST_DIVD;
			ST_DIVD: if (cnt_q == '0) state_nx = ST_FIN;
			ST_FIN:  if (!out_valid_q || out_ready) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// operand selection for the shared units
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		mul_a    = an_q;
		mul_b    = bd_q;
		sub_a    = x_q;
		sub_b    = y_q;
		unique case (state_q)
			ST_MUL0: if (cmd_q == OP_MUL) mul_b = bn_q;
			ST_MUL1: begin
				mul_a = ad_q;
				mul_b = bn_q;
			end
			ST_MUL2: begin
				mul_a = ad_q;
				mul_b = (cmd_q == OP_DIV) ? bn_q : bd_q;
			end
			ST_DIVN, ST_DIVD: begin
				sub_a = rem_sh;
				sub_b = g_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (fin_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd_q <= cmd;
					an_q  <= a_num;
					ad_q  <= a_den;
					bn_q  <= b_num;
					bd_q  <= b_den;
					num_q <= OUT_W'(a_num);
					den_q <= OUT_W'(a_den);
					err_q <= 1'b0;
					x_q   <= mag(a_num);
					y_q   <= mag(a_den);
					k_q   <= '0;
				end
			end
			ST_MUL0: prod_q <= mul_ext[OUT_W-1:0];
			ST_MUL1: begin
				prod_q <= mul_ext[OUT_W-1:0];
				num_q  <= prod_q;
			end
			ST_MUL2: begin
				prod_q <= mul_ext[OUT_W-1:0];
				if (cmd_q == OP_ADD)
					num_q <= num_q + prod_q;
				else if (cmd_q == OP_SUB)
					num_q <= num_q - prod_q;
			end
			ST_MUL3: den_q <= prod_q;
			ST_GCD: begin
				priority if (x_q == '0 && y_q == '0) begin
					err_q <= 1'b1;
				end else if (x_q == '0 || y_q == '0) begin
					g_q   <= gsrc << k_q;
					rem_q <= '0;
					quo_q <= mag(an_q);
					cnt_q <= CW'(W - 1);
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + CW'(1);
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else begin
					// both odd: keep the smaller, replace the other by the gap
					x_q <= ge ? y_q : x_q;
					y_q <= ge ? diff[W-1:0] : y_neg;
				end
			end
			ST_DIVN: begin
				if (cnt_q == '0) begin
					num_q <= apply_sign(quo_nx, an_q[W-1]);
					rem_q <= '0;
					quo_q <= mag(ad_q);
					cnt_q <= CW'(W - 1);
				end else begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - CW'(1);
				end
			end
			ST_DIVD: begin
				if (cnt_q == '0) begin
					den_q <= apply_sign(quo_nx, ad_q[W-1]);
				end else begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - CW'(1);
				end
			end
			default: ;
		endcase
		if (fin_load) begin
			res_num_q <= num_q;
			res_den_q <= den_q;
			res_err_q <= err_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign res_num             = res_num_q;
	assign res_den             = res_den_q;
	assign zero_fraction_error = res_err_q;

endmodule

/* rtl/fa_checker.sv */
// ----------------------------------------------------------------------------
// fa_checker
// Port-level checks of the fraction ALU, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fraction_alu_unit_macros.svh"

module fa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic signed [fa_pkg::OUT_W-1:0] res_num,
	input logic signed [fa_pkg::OUT_W-1:0] res_den,
	input logic                            zero_fraction_error
);

	import fa_pkg::*;

	// stalled result holds
	`FA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(res_num) && $stable(res_den) && $stable(zero_fraction_error))

	// one request at a time
	`FA_ASSERT_NXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready)

	// a fresh result is handed over only while the unit is busy
	`FA_ASSERT_NOW(a_load_when_busy, clk, arst_n, $rose(out_valid), !$past(in_ready))

	// 0/0 passes through as zero
	`FA_ASSERT_NOW(a_err_zero, clk, arst_n, out_valid && zero_fraction_error, res_num == '0 && res_den == '0)

endmodule

bind fraction_alu_unit fa_checker u_fa_checker (.*);
